FILE: hdl/spk_pkg.sv
// ----------------------------------------------------------------------------
// spk_pkg
// Shared types, size table and rotate helpers for the Speck cipher unit.
// ----------------------------------------------------------------------------
package spk_pkg;

  // Word and field widths fixed by the ports.
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned NW_W    = 7;   // holds a word width up to 64
  localparam int unsigned RND_W   = 6;   // holds a round count up to 34
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned NUM_ROWS = 10;

  // Commands of an input beat.
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY0 = 3'd1;
  localparam logic [2:0] REG_KEY1 = 3'd2;
  localparam logic [2:0] REG_KEY2 = 3'd3;
  localparam logic [2:0] REG_KEY3 = 3'd4;

  // One row of the size table.
  typedef struct packed {
    logic [NW_W-1:0]  width;
    logic [2:0]       words;
    logic [RND_W-1:0] rounds;
  } spk_row_t;

  // Settings that every round stage needs.
  typedef struct packed {
    logic [NW_W-1:0]   n;
    logic [WORD_W-1:0] mask;
    logic [NW_W-1:0]   alpha;
    logic [NW_W-1:0]   beta;
    logic [RND_W-1:0]  rounds;
  } spk_cfg_t;

  // Block data carried through the pipeline.
  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } spk_blk_t;

  // Size table lookup; rows past the end act as the last row.
  function automatic spk_row_t spk_row(input logic [SIZE_W-1:0] sel);
    spk_row_t r;
    case (sel)
      4'd0:    r = '{width: 7'd16, words: 3'd4, rounds: 6'd22};
      4'd1:    r = '{width: 7'd24, words: 3'd3, rounds: 6'd22};
      4'd2:    r = '{width: 7'd24, words: 3'd4, rounds: 6'd23};
      4'd3:    r = '{width: 7'd32, words: 3'd3, rounds: 6'd26};
      4'd4:    r = '{width: 7'd32, words: 3'd4, rounds: 6'd27};
      4'd5:    r = '{width: 7'd48, words: 3'd2, rounds: 6'd28};
      4'd6:    r = '{width: 7'd48, words: 3'd3, rounds: 6'd29};
      4'd7:    r = '{width: 7'd64, words: 3'd2, rounds: 6'd32};
      4'd8:    r = '{width: 7'd64, words: 3'd3, rounds: 6'd33};
      default: r = '{width: 7'd64, words: 3'd4, rounds: 6'd34};
    endcase
    return r;
  endfunction

  // Rotate left by a within an n-bit word.
  function automatic logic [WORD_W-1:0] spk_rotl(input logic [WORD_W-1:0] w,
                                                 input logic [NW_W-1:0] n,
                                                 input logic [NW_W-1:0] a,
                                                 input logic [WORD_W-1:0] mask);
    return ((w << a) | (w >> (n - a))) & mask;
  endfunction

  // Rotate right by a within an n-bit word.
  function automatic logic [WORD_W-1:0] spk_rotr(input logic [WORD_W-1:0] w,
                                                 input logic [NW_W-1:0] n,
                                                 input logic [NW_W-1:0] a,
                                                 input logic [WORD_W-1:0] mask);
    return spk_rotl(w, n, n - a, mask);
  endfunction

endpackage

FILE: hdl/spk_if.sv
// ----------------------------------------------------------------------------
// spk_in_if / spk_out_if
// Valid/ready channels for block beats and result beats.
// ----------------------------------------------------------------------------
interface spk_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] x_word;
  logic [63:0] y_word;
  modport source (output valid, command, x_word, y_word, input ready);
  modport sink   (input valid, command, x_word, y_word, output ready);
endinterface

interface spk_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] x_out;
  logic [63:0] y_out;
  modport source (output valid, x_out, y_out, input ready);
  modport sink   (input valid, x_out, y_out, output ready);
endinterface

FILE: hdl/spk_round.sv
// ----------------------------------------------------------------------------
// spk_round
// One registered Speck round; encrypts, decrypts or passes the beat through.
// ----------------------------------------------------------------------------
module spk_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              v_i,
  input  spk_pkg::spk_blk_t d_i,
  input  spk_pkg::spk_cfg_t cfg,
  input  logic [63:0]       enc_key,
  input  logic [63:0]       dec_key,
  input  logic              enc_on,
  input  logic              dec_on,
  output logic              v_o,
  output spk_pkg::spk_blk_t d_o
);

  logic              v_r;
  spk_pkg::spk_blk_t d_r;
  spk_pkg::spk_blk_t d_nxt;
  logic [63:0]       ex;
  logic [63:0]       dy;

  // Round function for the beat's direction.
  always_comb begin
    d_nxt = d_i;
    ex = ((spk_pkg::spk_rotr(d_i.x, cfg.n, cfg.alpha, cfg.mask) + d_i.y) & cfg.mask)
         ^ enc_key;
    dy = spk_pkg::spk_rotr(d_i.x ^ d_i.y, cfg.n, cfg.beta, cfg.mask);
    if (d_i.cmd == spk_pkg::CMD_ENCRYPT) begin
      if (enc_on) begin
        d_nxt.x = ex;
        d_nxt.y = spk_pkg::spk_rotl(d_i.y, cfg.n, cfg.beta, cfg.mask) ^ ex;
      end
    end else begin
      if (dec_on) begin
        d_nxt.y = dy;
        d_nxt.x = spk_pkg::spk_rotl(((d_i.x ^ dec_key) - dy) & cfg.mask, cfg.n,
                                    cfg.alpha, cfg.mask);
      end
    end
  end

  // Stage register; the whole pipe moves together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_i;
    end
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign v_o = v_r;
  assign d_o = d_r;

endmodule

FILE: hdl/spk_key_sched.sv
// ----------------------------------------------------------------------------
// spk_key_sched
// Configuration registers, APB port and the round key expansion engine.
// ----------------------------------------------------------------------------
module spk_key_sched #(
  parameter int unsigned MAX_ROUNDS     = 34,
  parameter int unsigned MAX_WORD_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output spk_pkg::spk_cfg_t cfg,
  output logic              keys_ready,
  output logic [63:0]       rk [MAX_ROUNDS]
);

  localparam int unsigned CW = $clog2(MAX_ROUNDS);

  typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_DONE} ks_state_t;

  ks_state_t         state_r;
  logic [3:0]        size_r;
  logic [63:0]       key0_r, key1_r, key2_r, key3_r;
  logic [63:0]       k_r;
  logic [63:0]       q0_r, q1_r, q2_r;
  logic [CW-1:0]     ctr_r;
  logic [63:0]       rk_r [MAX_ROUNDS];
  spk_pkg::spk_row_t row;
  logic [2:0]        idx;
  logic              wr;
  logic [63:0]       l_nxt;
  logic [63:0]       k_nxt;

  // Settings decoded from the size register.
  always_comb begin
    row = spk_pkg::spk_row(size_r);
    cfg.n = (row.width > 7'(MAX_WORD_WIDTH)) ? 7'(MAX_WORD_WIDTH) : row.width;
    cfg.mask = (cfg.n >= 7'd64) ? '1 : ((64'd1 << cfg.n) - 64'd1);
    cfg.alpha = (row.width == 7'd16) ? 7'd7 : 7'd8;
    cfg.beta  = (row.width == 7'd16) ? 7'd2 : 7'd3;
    cfg.rounds = (row.rounds > 6'(MAX_ROUNDS)) ? 6'(MAX_ROUNDS) : row.rounds;
  end

  // Register decode and read-back.
  assign idx = paddr[5:3];
  assign wr  = psel && penable && pwrite;

  always_comb begin
    unique case (idx)
      spk_pkg::REG_SIZE: prdata = {60'd0, size_r};
      spk_pkg::REG_KEY0: prdata = key0_r;
      spk_pkg::REG_KEY1: prdata = key1_r;
      spk_pkg::REG_KEY2: prdata = key2_r;
      spk_pkg::REG_KEY3: prdata = key3_r;
      default:           prdata = '0;
    endcase
  end

  // One key schedule step.
  always_comb begin
    l_nxt = ((k_r + spk_pkg::spk_rotr(q0_r, cfg.n, cfg.alpha, cfg.mask)) & cfg.mask)
            ^ 64'(ctr_r);
    k_nxt = spk_pkg::spk_rotl(k_r, cfg.n, cfg.beta, cfg.mask) ^ l_nxt;
  end

  // Registers and expansion sequencer; any write restarts the expansion.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      size_r  <= '0;
      key0_r  <= '0;
      key1_r  <= '0;
      key2_r  <= '0;
      key3_r  <= '0;
      ctr_r   <= '0;
    end else if (wr) begin
      state_r <= ST_LOAD;
      unique case (idx)
        spk_pkg::REG_SIZE: size_r <= pwdata[3:0];
        spk_pkg::REG_KEY0: key0_r <= pwdata;
        spk_pkg::REG_KEY1: key1_r <= pwdata;
        spk_pkg::REG_KEY2: key2_r <= pwdata;
        spk_pkg::REG_KEY3: key3_r <= pwdata;
        default: ;
      endcase
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          rk_r[0] <= key0_r & cfg.mask;
          k_r     <= key0_r & cfg.mask;
          q0_r    <= key1_r & cfg.mask;
          q1_r    <= key2_r & cfg.mask;
          q2_r    <= key3_r & cfg.mask;
          ctr_r   <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          rk_r[ctr_r + CW'(1)] <= k_nxt;
          k_r <= k_nxt;
          case (row.words)
            3'd2: q0_r <= l_nxt;
            3'd3: begin
              q0_r <= q1_r;
              q1_r <= l_nxt;
            end
            default: begin
              q0_r <= q1_r;
              q1_r <= q2_r;
              q2_r <= l_nxt;
            end
          endcase
          ctr_r <= ctr_r + CW'(1);
          if (6'(ctr_r) + 6'd2 == cfg.rounds) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: ;
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign keys_ready = (state_r == ST_DONE);
  assign rk = rk_r;

endmodule

FILE: hdl/speck_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// speck_block_cipher_unit: Speck cipher, one registered round stage per round.
// Every input beat passes through all round stages before its result beat.
// Throughput: one beat per cycle; a stalled result holds the whole pipe.
// After reset and after each register write the key engine expands the round
// keys, and no input beat is taken meanwhile.
// ----------------------------------------------------------------------------
module speck_block_cipher_unit #(
  parameter int unsigned MAX_ROUNDS     = 34,
  parameter int unsigned MAX_WORD_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  spk_in_if.sink      in_ch,
  spk_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  spk_pkg::spk_cfg_t cfg;
  logic              keys_ready;
  logic [63:0]       rk [MAX_ROUNDS];
  logic              adv;
  logic              v   [MAX_ROUNDS+1];
  spk_pkg::spk_blk_t d   [MAX_ROUNDS+1];

  spk_key_sched #(
    .MAX_ROUNDS     (MAX_ROUNDS),
    .MAX_WORD_WIDTH (MAX_WORD_WIDTH)
  ) u_keys (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .cfg        (cfg),
    .keys_ready (keys_ready),
    .rk         (rk)
  );

  assign cfg_pready = 1'b1;

  // The pipe moves whenever the result register is free or being taken.
  assign adv          = !v[MAX_ROUNDS] || out_ch.ready;
  assign in_ch.ready  = adv && keys_ready;

  // Entry: a taken beat is masked to the word width.
  assign v[0]     = in_ch.valid && in_ch.ready;
  assign d[0].cmd = in_ch.command;
  assign d[0].x   = in_ch.x_word & cfg.mask;
  assign d[0].y   = in_ch.y_word & cfg.mask;

  // Encryption uses stage s for round s; decryption ends with round key 0.
  for (genvar s = 0; s < MAX_ROUNDS; s++) begin : g_rnd
    localparam int unsigned DI = MAX_ROUNDS - 1 - s;
    spk_round u_rnd (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .v_i     (v[s]),
      .d_i     (d[s]),
      .cfg     (cfg),
      .enc_key (rk[s]),
      .dec_key (rk[DI]),
      .enc_on  (6'(s) < cfg.rounds),
      .dec_on  (6'(DI) < cfg.rounds),
      .v_o     (v[s+1]),
      .d_o     (d[s+1])
    );
  end

  assign out_ch.valid = v[MAX_ROUNDS];
  assign out_ch.x_out = d[MAX_ROUNDS].x;
  assign out_ch.y_out = d[MAX_ROUNDS].y;

endmodule

FILE: hdl/spk_checker.sv
// ----------------------------------------------------------------------------
// spk_checker
// Port-level checks of the cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
module spk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_x,
  input logic [63:0] out_y,
  input logic        cfg_wr
);

  // No result beat in the cycle after a reset cycle.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // A register write starts a key expansion, so input must pause.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_ready)
    else $error("input taken during key expansion");

  // A stalled result beat stays.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y))
    else $error("result payload changed while stalled");

endmodule

bind speck_block_cipher_unit spk_checker u_spk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.x_out),
  .out_y     (out_ch.y_out),
  .cfg_wr    (cfg_psel && cfg_penable && cfg_pwrite)
);
